// File: rtl/core/ple_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the positional list engine.
// No dependencies; used by ple_cell, ple_chain and the top level.
package ple_pkg;

  localparam int DATA_W       = 32;
  localparam int KIND_W       = 2;
  localparam int POS_W        = 8;
  localparam int COUNT_W      = 7;
  localparam int CAPACITY_DEF = 64;
  localparam int GROUP_SIZE   = 8;

  localparam logic [KIND_W-1:0] KIND_READ   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd2;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd3;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic              apply;    // request succeeded and may change the store
    logic              read_en;  // request returns the value at the position
    logic [KIND_W-1:0] kind;
  } cell_cmd_t;

endpackage

// File: rtl/core/positional_list_engine_unit.sv
`timescale 1ns / 1ps
// Positional list engine: ordered list of signed 32-bit entries kept in a
// row of cells, addressed by 1-based position. Depends on ple_pkg, ple_chain.
//
// Usage:
//   Request channel (in_valid/in_stall): kind, position, new_value. Kind 0
//   reads, 1 overwrites, 2 inserts before position (count+1 appends), 3
//   removes. Result channel (out_valid/out_stall): ok, data_out, count,
//   is_empty. Every request gives exactly one result, in order.
//   Status and read values are registered at the transfer, then in the
//   output register. One request per cycle is sustained unless the
//   receiver stalls: every cell decides shift, keep or load in parallel
//   at the transfer, and the read value passes a two-level OR tree (groups
//   of eight cells, then the groups). When the receiver stalls, the result
//   stays in the output register and one more request may enter the
//   middle stage; then the request side sees in_stall until it is taken.
//   Reset empties the list and drops any request in flight; entry contents
//   are not cleared and are never read before written.
module positional_list_engine_unit
  import ple_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [KIND_W-1:0]        kind,
  input  logic [POS_W-1:0]         position,
  input  logic signed [DATA_W-1:0] new_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     ok,
  output logic signed [DATA_W-1:0] data_out,
  output logic [COUNT_W-1:0]       count,
  output logic                     is_empty
);

  localparam int IDX_W   = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int CMP_W   = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam int NGROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

  logic [CNT_W-1:0]  entry_count;
  logic [CNT_W-1:0]  entry_count_next;
  logic [CMP_W-1:0]  pos_ext;
  logic [CMP_W-1:0]  cnt_ext;
  logic [CMP_W-1:0]  pos_m1;
  logic [IDX_W-1:0]  pos_idx;
  logic              pos_nz;
  logic              in_range;
  logic              ins_range;
  logic              not_full;
  logic              req_ok;
  logic              in_xfer;
  logic              s1_adv;
  cell_cmd_t         cmd;
  logic [DATA_W-1:0] group_data [NGROUPS];
  logic [DATA_W-1:0] data_or;

  logic              s1_valid;
  logic              s1_ok;
  logic [CNT_W-1:0]  s1_count;

  assign pos_ext   = CMP_W'(position);
  assign cnt_ext   = CMP_W'(entry_count);
  assign pos_m1    = pos_ext - CMP_W'(1);
  assign pos_idx   = pos_m1[IDX_W-1:0];
  assign pos_nz    = (position != '0);
  assign in_range  = pos_nz && (pos_ext <= cnt_ext);
  assign ins_range = pos_nz && (pos_ext <= cnt_ext + CMP_W'(1));
  assign not_full  = (cnt_ext < CMP_W'(CAPACITY));

  always_comb begin
    case (kind)
      KIND_INSERT: req_ok = ins_range && not_full;
      default:     req_ok = in_range;
    endcase
  end

  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;
  assign in_xfer  = in_valid && !in_stall;

  assign cmd.apply   = in_xfer && req_ok;
  assign cmd.read_en = req_ok && ((kind == KIND_READ) || (kind == KIND_REMOVE));
  assign cmd.kind    = kind;

  always_comb begin
    entry_count_next = entry_count;
    if (cmd.apply) begin
      case (kind)
        KIND_INSERT: entry_count_next = entry_count + CNT_W'(1);
        KIND_REMOVE: entry_count_next = entry_count - CNT_W'(1);
        default:     entry_count_next = entry_count;
      endcase
    end
  end

  ple_chain #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W),
    .NGROUPS  (NGROUPS)
  ) u_chain (
    .clk        (clk),
    .capture    (in_xfer),
    .cmd        (cmd),
    .pos_idx    (pos_idx),
    .new_value  (new_value),
    .group_data (group_data)
  );

  always_comb begin
    data_or = '0;
    for (int g = 0; g < NGROUPS; g++) begin
      data_or = data_or | group_data[g];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      entry_count <= entry_count_next;
      if (in_xfer) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_ok    <= req_ok;
      s1_count <= entry_count_next;
    end
    if (s1_adv) begin
      ok       <= s1_ok;
      data_out <= data_or;
      count    <= COUNT_W'(s1_count);
      is_empty <= (s1_count == '0);
    end
  end

endmodule

// File: rtl/core/ple_cell.sv
`timescale 1ns / 1ps
// One storage cell of the list: keeps one entry and shifts, keeps or loads.
// Depends on ple_pkg.
module ple_cell
  import ple_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int IDX_W = 6
) (
  input  logic                     clk,
  input  cell_cmd_t                cmd,
  input  logic [IDX_W-1:0]         pos_idx,
  input  logic signed [DATA_W-1:0] new_value,
  input  logic signed [DATA_W-1:0] left_value,
  input  logic signed [DATA_W-1:0] right_value,
  output logic signed [DATA_W-1:0] value,
  output logic signed [DATA_W-1:0] tap
);

  logic                     hit;
  logic                     after;
  logic                     load;
  logic signed [DATA_W-1:0] value_next;

  assign hit   = (pos_idx == IDX_W'(IDX));
  assign after = (pos_idx < IDX_W'(IDX));

  always_comb begin
    load       = 1'b0;
    value_next = value;
    case (cmd.kind)
      KIND_WRITE: begin
        if (hit) begin
          load       = cmd.apply;
          value_next = new_value;
        end
      end
      KIND_INSERT: begin
        if (hit) begin
          load       = cmd.apply;
          value_next = new_value;
        end else if (after) begin
          load       = cmd.apply;
          value_next = left_value;
        end
      end
      KIND_REMOVE: begin
        if (hit || after) begin
          load       = cmd.apply;
          value_next = right_value;
        end
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value <= value_next;
    end
  end

  // Only the addressed cell puts its value on the read tap.
  assign tap = (cmd.read_en && hit) ? value : '0;

endmodule

// File: rtl/core/ple_chain.sv
`timescale 1ns / 1ps
// Row of list cells wired to their neighbors, plus the registered first
// level of the read tree. Depends on ple_pkg and ple_cell.
module ple_chain
  import ple_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int IDX_W    = 6,
  parameter int NGROUPS  = 8
) (
  input  logic                     clk,
  input  logic                     capture,
  input  cell_cmd_t                cmd,
  input  logic [IDX_W-1:0]         pos_idx,
  input  logic signed [DATA_W-1:0] new_value,
  output logic [DATA_W-1:0]        group_data [NGROUPS]
);

  logic signed [DATA_W-1:0] values [CAPACITY];
  logic signed [DATA_W-1:0] taps   [CAPACITY];
  logic [DATA_W-1:0]        group_or [NGROUPS];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_v;
    logic signed [DATA_W-1:0] right_v;

    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = values[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = values[i+1];
    end

    ple_cell #(
      .IDX   (i),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .pos_idx     (pos_idx),
      .new_value   (new_value),
      .left_value  (left_v),
      .right_value (right_v),
      .value       (values[i]),
      .tap         (taps[i])
    );
  end

  for (genvar g = 0; g < NGROUPS; g++) begin : g_group
    always_comb begin
      group_or[g] = '0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        if (g * GROUP_SIZE + k < CAPACITY) begin
          group_or[g] = group_or[g] | taps[g * GROUP_SIZE + k];
        end
      end
    end

    // Taps reflect the store before this transfer changes it.
    always_ff @(posedge clk) begin
      if (capture) begin
        group_data[g] <= group_or[g];
      end
    end
  end

endmodule
